>>> hw/rtl/dq_pkg.sv
// Shared types and defaults for the double-ended queue.
package dq_pkg;

    localparam int DQ_DEPTH      = 16;
    localparam int DQ_DATA_WIDTH = 32;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

>>> hw/rtl/dq_store.sv
// Entry store: single-port synchronous RAM with a registered read.
module dq_store #(
    parameter int DEPTH      = dq_pkg::DQ_DEPTH,
    parameter int DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [DATA_WIDTH-1:0]    i_wdata,
    output logic [DATA_WIDTH-1:0]    o_rdata
);
    import dq_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/double_ended_queue_core.sv
// Double-ended queue top level: ring buffer in one RAM, head and count in flops.
// The result beat appears in the cycle after the request is taken.
// Throughput: one request per cycle once busy is low; the single RAM port does the one write or read.
// Reset (i_rst_n low, synchronous) clears head, count and the result strobe;
// busy is high until the first clock after reset. Store contents are not cleared.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module double_ended_queue_core #(
    parameter int DEPTH      = dq_pkg::DQ_DEPTH,
    parameter int DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  dq_pkg::t_req               i_req_type,
    input  logic signed [DATA_WIDTH-1:0] i_push_value,
    output logic                       o_result_valid,
    output logic signed [DATA_WIDTH-1:0] o_pop_value,
    output dq_pkg::t_status            o_status,
    output logic                       o_is_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_occupancy
);
    import dq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    logic          r_run;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic          r_valid;
    logic          r_popped, n_popped;
    t_status       r_status, n_status;

    logic          accept;
    logic          we, re;
    logic [AW-1:0] addr;
    logic [AW-1:0] head_dec, head_inc;
    logic [CW-1:0] back_off;
    logic [SW-1:0] back_sum;
    logic [AW-1:0] back_slot;
    logic [DATA_WIDTH-1:0] rdata;

    assign busy   = ~r_run;
    assign accept = start & ~busy;

    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

    // back push writes at head+count, back pop reads at head+count-1 (mod DEPTH)
    assign back_off  = (i_req_type == REQ_PUSH_BACK) ? r_count : r_count - CW'(1);
    assign back_sum  = SW'(r_head) + SW'(back_off);
    assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH))
                                                : back_sum[AW-1:0];

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_popped = 1'b0;
        n_status = ST_OK;
        we       = 1'b0;
        re       = 1'b0;
        addr     = back_slot;
        if (accept) begin
            case (i_req_type)
                REQ_PUSH_FRONT: begin
                    if (r_count == CW'(DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        addr    = head_dec;
                        we      = 1'b1;
                        n_head  = head_dec;
                        n_count = r_count + CW'(1);
                    end
                end
                REQ_PUSH_BACK: begin
                    if (r_count == CW'(DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        we      = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
                REQ_POP_FRONT: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        addr     = r_head;
                        re       = 1'b1;
                        n_popped = 1'b1;
                        n_head   = head_inc;
                        n_count  = r_count - CW'(1);
                    end
                end
                REQ_POP_BACK: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        re       = 1'b1;
                        n_popped = 1'b1;
                        n_count  = r_count - CW'(1);
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    dq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_re    (re),
        .i_addr  (addr),
        .i_wdata (i_push_value),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_head   <= '0;
            r_count  <= '0;
            r_valid  <= 1'b0;
            r_popped <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_run    <= 1'b1;
            r_head   <= n_head;
            r_count  <= n_count;
            r_valid  <= accept;
            r_popped <= n_popped;
            r_status <= n_status;
        end
    end

    // popped word comes straight off the RAM's read register
    assign o_result_valid = r_valid;
    assign o_pop_value    = r_popped ? rdata : '0;
    assign o_status       = r_status;
    assign o_is_empty     = (r_count == '0);
    assign o_occupancy    = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_beat_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_result_valid)
        else $error("request without result beat");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != ST_OK) |->
            (o_pop_value == '0 && r_count == $past(r_count) && r_head == $past(r_head)))
        else $error("rejected request changed state");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == ST_EMPTY) |-> o_is_empty)
        else $error("empty status with entries held");

endmodule
